// ----- design/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  // outcome codes
  typedef enum logic [1:0] {
    OUT_TWO       = 2'd0,
    OUT_DOUBLE    = 2'd1,
    OUT_NONE      = 2'd2,
    OUT_LEAD_ZERO = 2'd3
  } outcome_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_TOL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_TOL = 8'd1;

  // datapath widths
  localparam int DISC_W  = 67;  // discriminant magnitude, Q35.32
  localparam int SQ_BITS = 35;  // square root bits
  localparam int REM_W   = 72;  // square root remainder and trial
  localparam int NUM_W   = 35;  // numerator magnitude
  localparam int DVS_W   = 33;  // divisor 2*|a|
  localparam int DIV_BITS = NUM_W + 16;  // dividend and quotient bits

  // item state carried through the square root pipeline
  typedef struct packed {
    outcome_t           outcome;
    logic signed [32:0] neg_b;
    logic [31:0]        a_mag;
    logic               a_neg;
  } side_t;

  // item state carried alongside the dividers
  typedef struct packed {
    outcome_t outcome;
    logic     neg_p;
    logic     neg_m;
  } div_side_t;

  // one result item
  typedef struct packed {
    outcome_t    outcome;
    logic [31:0] root_plus;
    logic [31:0] root_minus;
    logic        saturated;
  } result_t;

endpackage

`default_nettype wire

// ----- design/qrs_ifs.sv -----
// ----------------------------------------------------------------------------
// qrs_ifs
// Handshake channels of the quadratic root solver: coefficients, roots and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrs_coef_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic signed [31:0] root_plus;
  logic signed [31:0] root_minus;
  logic               saturated;
  modport source (output valid, outcome, root_plus, root_minus, saturated, input ready);
  modport sink (input valid, outcome, root_plus, root_minus, saturated, output ready);
endinterface

interface qrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/qrs_front.sv -----
// ----------------------------------------------------------------------------
// qrs_front
// Two stages: magnitude products, then exact discriminant and classification.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [31:0]                coef_a,
  input  logic signed [31:0]                coef_b,
  input  logic signed [31:0]                coef_c,
  input  logic [15:0]                       lead_tol,
  input  logic [31:0]                       disc_tol,
  output logic                              out_valid,
  output qrs_pkg::side_t                    out_side,
  output logic [qrs_pkg::DISC_W-1:0]        out_disc
);
  import qrs_pkg::*;

  logic [31:0] a_mag_c, b_mag_c, c_mag_c;
  logic        v1;
  logic [63:0] p1, q1;
  logic [31:0] a_mag1;
  logic        a_neg1, c_neg1;
  logic signed [31:0] b1;
  logic [DISC_W-1:0] p_x, q_x, disc_c;
  logic        disc_neg;
  logic        disc_small;
  outcome_t    outcome_c;

  // magnitudes
  always_comb begin
    a_mag_c = coef_a[31] ? 32'(-coef_a) : 32'(coef_a);
    b_mag_c = coef_b[31] ? 32'(-coef_b) : 32'(coef_b);
    c_mag_c = coef_c[31] ? 32'(-coef_c) : 32'(coef_c);
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  // stage 1 products
  always_ff @(posedge clk) begin
    if (en) begin
      p1     <= 64'(b_mag_c) * 64'(b_mag_c);
      q1     <= 64'(a_mag_c) * 64'(c_mag_c);
      a_mag1 <= a_mag_c;
      a_neg1 <= coef_a[31];
      c_neg1 <= coef_c[31];
      b1     <= coef_b;
    end
  end

  // discriminant b*b - 4ac as sign and magnitude
  always_comb begin
    p_x = DISC_W'(p1);
    q_x = {1'b0, q1, 2'b00};
    disc_neg = 1'b0;
    if (a_neg1 != c_neg1) begin
      disc_c = p_x + q_x;
    end else if (q_x <= p_x) begin
      disc_c = p_x - q_x;
    end else begin
      disc_c = q_x - p_x;
      disc_neg = 1'b1;
    end
    disc_small = (disc_c[DISC_W-1:32] == '0) && (disc_c[31:0] <= disc_tol);
    if (a_mag1 <= 32'(lead_tol)) begin
      outcome_c = OUT_LEAD_ZERO;
    end else if (disc_neg && !disc_small) begin
      outcome_c = OUT_NONE;
    end else if (disc_small) begin
      outcome_c = OUT_DOUBLE;
    end else begin
      outcome_c = OUT_TWO;
    end
  end

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_disc         <= disc_c;
      out_side.outcome <= outcome_c;
      out_side.neg_b   <= -{b1[31], b1};
      out_side.a_mag   <= a_mag1;
      out_side.a_neg   <= a_neg1;
    end
  end

endmodule

`default_nettype wire

// ----- design/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Integer square root of the discriminant, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  qrs_pkg::side_t                    in_side,
  input  logic [qrs_pkg::DISC_W-1:0]        in_disc,
  output logic                              out_valid,
  output qrs_pkg::side_t                    out_side,
  output logic [qrs_pkg::SQ_BITS-1:0]       out_root
);
  import qrs_pkg::*;

  logic               vld [SQ_BITS+1];
  side_t              sd  [SQ_BITS+1];
  logic [REM_W-1:0]   rem [SQ_BITS+1];
  logic [SQ_BITS-1:0] rt  [SQ_BITS+1];

  assign vld[0] = in_valid;
  assign sd[0]  = in_side;
  assign rem[0] = REM_W'(in_disc);
  assign rt[0]  = '0;

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_stage
    localparam int BIT = SQ_BITS - 1 - k;
    logic [REM_W-1:0] trial;
    logic             take;

    // trial subtrahend 2*r*2^bit + 2^(2*bit)
    always_comb begin
      trial = (REM_W'(rt[k]) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
      take  = rem[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1]  <= sd[k];
        rem[k+1] <= take ? rem[k] - trial : rem[k];
        rt[k+1]  <= take ? (rt[k] | (SQ_BITS'(1) << BIT)) : rt[k];
      end
    end
  end

  assign out_valid = vld[SQ_BITS];
  assign out_side  = sd[SQ_BITS];
  assign out_root  = rt[SQ_BITS];

endmodule

`default_nettype wire

// ----- design/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [qrs_pkg::DIV_BITS-1:0]      dividend,
  input  logic [qrs_pkg::DVS_W-1:0]         divisor,
  output logic [qrs_pkg::DIV_BITS-1:0]      quotient
);
  import qrs_pkg::*;

  logic [DIV_BITS-1:0] num [DIV_BITS+1];
  logic [DVS_W-1:0]    dvs [DIV_BITS+1];
  logic [DVS_W-1:0]    rem [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo [DIV_BITS+1];

  assign num[0] = dividend;
  assign dvs[0] = divisor;
  assign rem[0] = '0;
  assign quo[0] = '0;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    localparam int BIT = DIV_BITS - 1 - k;
    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           take;

    // shift in the next dividend bit and try the subtraction
    always_comb begin
      shifted = {rem[k], num[k][BIT]};
      diff    = shifted - {1'b0, dvs[k]};
      take    = shifted >= {1'b0, dvs[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1] <= num[k];
        dvs[k+1] <= dvs[k];
        rem[k+1] <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo[k+1] <= take ? (quo[k] | (DIV_BITS'(1) << BIT)) : quo[k];
      end
    end
  end

  assign quotient = quo[DIV_BITS];

endmodule

`default_nettype wire

// ----- design/quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 for Q16.16 coefficients.
// ----------------------------------------------------------------------------
// The block takes one coefficient item per cycle while the output buffer has
// room and returns one result item for each, in order, through these stages:
// two product/discriminant stages, 35 square root stages (one root bit each),
// one numerator stage, 51 divider stages (one quotient bit each, two dividers
// side by side for the two roots) and one saturation stage. A two-entry
// output buffer keeps accepting items while a result waits to be taken; the
// whole pipeline holds only when that buffer is full. Configuration writes
// take effect at once and are always accepted.
`default_nettype none

module quadratic_root_solver (
  input  logic            clk,
  input  logic            rst,
  qrs_cfg_if.sink         cfg,
  qrs_coef_if.sink        coef,
  qrs_root_if.source      root
);
  import qrs_pkg::*;

  logic [15:0] lead_tol;
  logic [31:0] disc_tol;
  logic        en;

  logic              fr_valid;
  side_t             fr_side;
  logic [DISC_W-1:0] fr_disc;

  logic               sq_valid;
  side_t              sq_side;
  logic [SQ_BITS-1:0] sq_root;

  logic signed [35:0] nb_x, s_x, num_p, num_m;
  logic               nm_valid;
  logic [NUM_W-1:0]   mag_p, mag_m;
  logic [DVS_W-1:0]   dvs;
  div_side_t          nm_side;

  logic      dl_v [DIV_BITS+1];
  div_side_t dl_s [DIV_BITS+1];

  logic [DIV_BITS-1:0] quo_p, quo_m;
  logic [32:0]         fin_p, fin_m;
  logic                fin_valid;
  result_t             fin_res;

  result_t     ent [2];
  logic [1:0]  cnt;
  logic        wr_ptr, rd_ptr;
  logic        push, pop;

  // clamp a quotient to Q16.16 and apply the sign; bit 32 flags saturation
  function automatic logic [32:0] clamp_root(input logic [DIV_BITS-1:0] q,
                                             input logic neg);
    logic [32:0] res;
    if (!neg) begin
      if (q[DIV_BITS-1:31] != '0) res = {1'b1, 32'h7FFF_FFFF};
      else                        res = {1'b0, q[31:0]};
    end else begin
      if ((q[DIV_BITS-1:32] != '0) || (q[31] && (q[30:0] != '0)))
        res = {1'b1, 32'h8000_0000};
      else
        res = {1'b0, 32'(-q[31:0])};
    end
    return res;
  endfunction

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_tol <= '0;
      disc_tol <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LEAD_TOL: lead_tol <= cfg.data[15:0];
        REG_DISC_TOL: disc_tol <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline advances while the output buffer has room
  assign en         = (cnt != 2'd2);
  assign coef.ready = en;

  qrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (coef.valid),
    .coef_a   (coef.coef_a),
    .coef_b   (coef.coef_b),
    .coef_c   (coef.coef_c),
    .lead_tol (lead_tol),
    .disc_tol (disc_tol),
    .out_valid(fr_valid),
    .out_side (fr_side),
    .out_disc (fr_disc)
  );

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (fr_valid),
    .in_side  (fr_side),
    .in_disc  (fr_disc),
    .out_valid(sq_valid),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  // numerators -b + s and -b - s, or -b alone for a double root
  always_comb begin
    nb_x = 36'(sq_side.neg_b);
    s_x  = {1'b0, sq_root};
    if (sq_side.outcome == OUT_DOUBLE) begin
      num_p = nb_x;
      num_m = nb_x;
    end else begin
      num_p = nb_x + s_x;
      num_m = nb_x - s_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (en) begin
      nm_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_p <= num_p[35] ? NUM_W'(-num_p) : NUM_W'(num_p);
      mag_m <= num_m[35] ? NUM_W'(-num_m) : NUM_W'(num_m);
      dvs   <= {sq_side.a_mag, 1'b0};
      nm_side.outcome <= sq_side.outcome;
      nm_side.neg_p   <= num_p[35] ^ sq_side.a_neg;
      nm_side.neg_m   <= num_m[35] ^ sq_side.a_neg;
    end
  end

  // dividers for both roots
  qrs_div u_div_p (
    .clk     (clk),
    .en      (en),
    .dividend({mag_p, 16'h0000}),
    .divisor (dvs),
    .quotient(quo_p)
  );

  qrs_div u_div_m (
    .clk     (clk),
    .en      (en),
    .dividend({mag_m, 16'h0000}),
    .divisor (dvs),
    .quotient(quo_m)
  );

  // item state alongside the dividers
  assign dl_v[0] = nm_valid;
  assign dl_s[0] = nm_side;
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        dl_v[k+1] <= 1'b0;
      end else if (en) begin
        dl_v[k+1] <= dl_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dl_s[k+1] <= dl_s[k];
      end
    end
  end

  // saturation and final result
  always_comb begin
    fin_p = clamp_root(quo_p, dl_s[DIV_BITS].neg_p);
    fin_m = clamp_root(quo_m, dl_s[DIV_BITS].neg_m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= dl_v[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_res.outcome <= dl_s[DIV_BITS].outcome;
      if (dl_s[DIV_BITS].outcome == OUT_TWO || dl_s[DIV_BITS].outcome == OUT_DOUBLE) begin
        fin_res.root_plus  <= fin_p[31:0];
        fin_res.root_minus <= fin_m[31:0];
        fin_res.saturated  <= fin_p[32] | fin_m[32];
      end else begin
        fin_res.root_plus  <= '0;
        fin_res.root_minus <= '0;
        fin_res.saturated  <= 1'b0;
      end
    end
  end

  // two-entry output buffer
  assign push = en && fin_valid;
  assign pop  = root.valid && root.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= fin_res;
    end
  end

  assign root.valid      = (cnt != 2'd0);
  assign root.outcome    = ent[rd_ptr].outcome;
  assign root.root_plus  = ent[rd_ptr].root_plus;
  assign root.root_minus = ent[rd_ptr].root_minus;
  assign root.saturated  = ent[rd_ptr].saturated;

endmodule

`default_nettype wire

// ----- design/qrs_checker.sv -----
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks on the root channel of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [1:0]  outcome,
  input logic [31:0] root_plus,
  input logic [31:0] root_minus,
  input logic        saturated
);
  import qrs_pkg::*;

  // a stalled item holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable({outcome, root_plus, root_minus, saturated}))
    else $error("root item changed while stalled");

  // no roots means zero fields
  a_no_roots: assert property (@(posedge clk) disable iff (rst)
    valid && (outcome == OUT_NONE || outcome == OUT_LEAD_ZERO) |->
      root_plus == '0 && root_minus == '0 && !saturated)
    else $error("roots reported without real roots");

  // a double root is reported twice
  a_double: assert property (@(posedge clk) disable iff (rst)
    valid && outcome == OUT_DOUBLE |-> root_plus == root_minus)
    else $error("double root differs");

  // saturation shows a clamped value
  a_sat: assert property (@(posedge clk) disable iff (rst)
    valid && saturated |->
      root_plus == 32'h7FFF_FFFF || root_plus == 32'h8000_0000 ||
      root_minus == 32'h7FFF_FFFF || root_minus == 32'h8000_0000)
    else $error("saturation flag without clamped root");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk       (clk),
  .rst       (rst),
  .valid     (root.valid),
  .ready     (root.ready),
  .outcome   (root.outcome),
  .root_plus (root.root_plus),
  .root_minus(root.root_minus),
  .saturated (root.saturated)
);

`default_nettype wire

// ----- dv/tb_quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Drives coefficient items through the root solver under random source gaps
// and sink stalls, predicts every result in fixed point and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int RANDOM_ITEMS   = 1100;

  typedef struct {
    logic [31:0] a, b, c;
    bit          known;
    outcome_t    outcome;
    logic [31:0] rp, rm;
    logic        sat;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrs_cfg_if  cfg ();
  qrs_coef_if coef ();
  qrs_root_if root ();

  quadratic_root_solver DUT (.clk(clk), .rst(rst), .cfg(cfg), .coef(coef), .root(root));

  always #2 clk = ~clk;

  // predictor registers
  logic [15:0] lead_tol;
  logic [31:0] disc_tol;

  result_t     roots_due[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          stall_enable = 1'b1;

  // floor square root of a 67 bit magnitude
  function automatic logic [34:0] floor_sqrt(logic [66:0] d);
    logic [34:0]  r;
    logic [34:0]  t;
    logic [69:0]  sq;
    r = '0;
    for (int i = 34; i >= 0; i--) begin
      t = r | (35'd1 << i);
      sq = t * t;
      if (sq <= {3'b0, d}) r = t;
    end
    return r;
  endfunction

  // quotient num*2^16/(2|a|), signed and clamped
  function automatic logic [31:0] root_quotient(logic signed [35:0] num, logic [31:0] am,
                                                logic aneg, inout logic sat);
    logic [35:0] nm;
    logic [51:0] q;
    logic        neg;
    nm = num < 0 ? -num : num;
    neg = (num < 0) != aneg;
    q = ({16'b0, nm} << 16) / ({19'b0, am, 1'b0});
    if (nm == 0) return 32'd0;
    if (!neg) begin
      if (q > 52'h7FFFFFFF) begin
        sat = 1'b1;
        return 32'h7FFFFFFF;
      end
      return q[31:0];
    end
    if (q > 52'h80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return -q[31:0];
  endfunction

  function automatic result_t solve_roots(logic [31:0] a_raw, b_raw, c_raw);
    logic signed [31:0]  a, b, c;
    logic signed [67:0]  disc;
    logic [66:0]         dmag;
    logic [31:0]         am;
    logic signed [35:0]  nb, s;
    result_t             r;
    a = a_raw; b = b_raw; c = c_raw;
    r = '{OUT_TWO, 32'd0, 32'd0, 1'b0};
    disc = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
    dmag = disc < 0 ? 67'(-disc) : 67'(disc);
    am = a < 0 ? 32'(-33'(a)) : 32'(a);
    nb = -36'(b);
    if (am <= {16'b0, lead_tol}) r.outcome = OUT_LEAD_ZERO;
    else if (dmag <= {35'b0, disc_tol}) begin
      r.outcome = OUT_DOUBLE;
      r.root_plus = root_quotient(nb, am, a < 0, r.saturated);
      r.root_minus = r.root_plus;
    end else if (disc < 0) r.outcome = OUT_NONE;
    else begin
      s = {1'b0, floor_sqrt(dmag)};
      r.root_plus = root_quotient(nb + s, am, a < 0, r.saturated);
      r.root_minus = root_quotient(nb - s, am, a < 0, r.saturated);
    end
    return r;
  endfunction

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      root.ready <= 1'b0;
    end else begin
      root.ready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (root.valid && root.ready) begin
        if (roots_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %0d", root.outcome);
        end else begin
          want = roots_due.pop_front();
          if (root.outcome !== want.outcome || root.root_plus !== want.root_plus ||
              root.root_minus !== want.root_minus || root.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %h %h %b got %0d %h %h %b", want.outcome,
                       want.root_plus, want.root_minus, want.saturated, root.outcome,
                       root.root_plus, root.root_minus, root.saturated);
          end
        end
      end
    end
  end

  // watchdog on accepted items
  always @(posedge clk) begin
    if ((coef.valid && coef.ready) || (root.valid && root.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_LEAD_TOL) lead_tol = val[15:0];
    else if (idx == REG_DISC_TOL) disc_tol = val;
    @(posedge clk);
  endtask

  // one coefficient item; known rows also checked against typed values
  task automatic send_coefs(row_t row);
    result_t want;
    coef.valid <= 1'b1;
    coef.coef_a <= row.a;
    coef.coef_b <= row.b;
    coef.coef_c <= row.c;
    do @(posedge clk); while (!coef.ready);
    want = solve_roots(row.a, row.b, row.c);
    if (row.known && (want.outcome != row.outcome || want.root_plus != row.rp ||
                      want.root_minus != row.rm || want.saturated != row.sat)) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %h %h %h", row.a, row.b, row.c);
    end
    roots_due.push_back(want);
    if ($urandom_range(0, 7) == 0) begin
      coef.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    coef.valid <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      1: return $signed($urandom_range(0, 8)) - 4 <<< 16;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 40) : -$urandom_range(0, 40);
      3: return 32'($signed(16'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  row_t directed[] = '{
    '{32'h0, 32'h0, 32'h0, 1, OUT_LEAD_ZERO, 32'h0, 32'h0, 1'b0},
    '{32'h0, 32'h7FFFFFFF, 32'h80000000, 1, OUT_LEAD_ZERO, 32'h0, 32'h0, 1'b0},
    '{32'h10000, 32'h0, 32'h10000, 1, OUT_NONE, 32'h0, 32'h0, 1'b0},
    '{32'h10000, 32'h0, 32'h0, 1, OUT_DOUBLE, 32'h0, 32'h0, 1'b0},
    '{32'h10000, 32'hFFFE0000, 32'h10000, 1, OUT_DOUBLE, 32'h10000, 32'h10000, 1'b0},
    '{32'h10000, 32'h0, 32'hFFFF0000, 1, OUT_TWO, 32'h10000, 32'hFFFF0000, 1'b0},
    '{32'h1, 32'h80000000, 32'h0, 1, OUT_TWO, 32'h7FFFFFFF, 32'h0, 1'b1},
    '{32'h80000000, 32'h0, 32'h0, 0, OUT_TWO, 0, 0, 0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 0, OUT_TWO, 0, 0, 0},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, OUT_TWO, 0, 0, 0},
    '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0, OUT_TWO, 0, 0, 0},
    '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h1, 0, OUT_TWO, 0, 0, 0},
    '{32'h20000, 32'hFFFD0000, 32'h10000, 0, OUT_TWO, 0, 0, 0},
    '{32'hFFFF0000, 32'h30000, 32'h40000, 0, OUT_TWO, 0, 0, 0},
    '{32'h1, 32'h1, 32'h1, 0, OUT_TWO, 0, 0, 0}
  };

  initial begin
    row_t row;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    coef.valid = 1'b0; coef.coef_a = '0; coef.coef_b = '0; coef.coef_c = '0;
    lead_tol = '0; disc_tol = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset tolerances, then at maximum tolerances
    foreach (directed[i]) send_coefs(directed[i]);
    drain();
    write_reg(REG_LEAD_TOL, 32'h0000FFFF);
    write_reg(REG_DISC_TOL, 32'hFFFFFFFF);
    write_reg(8'd7, 32'h12345678);
    foreach (directed[i]) begin
      row = directed[i];
      row.known = 0;
      send_coefs(row);
    end
    drain();

    // random phases over several tolerance settings
    for (int ph = 0; ph < 4; ph++) begin
      stall_enable = (ph != 2);
      case (ph)
        0: begin write_reg(REG_LEAD_TOL, 0); write_reg(REG_DISC_TOL, 0); end
        1: begin write_reg(REG_LEAD_TOL, $urandom); write_reg(REG_DISC_TOL, $urandom); end
        2: begin write_reg(REG_LEAD_TOL, 16); write_reg(REG_DISC_TOL, 32'h10000); end
        default: begin write_reg(REG_LEAD_TOL, 32'hFFFF); write_reg(REG_DISC_TOL, 32'hFFFFFFFF); end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        row = '{rand_coef(), rand_coef(), rand_coef(), 0, OUT_TWO, 0, 0, 0};
        send_coefs(row);
      end
      drain();
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

`default_nettype wire
